[src/playfair_digraph_cipher_defines.svh]
// Assertion macros shared by the Playfair cipher RTL
`ifndef PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PFC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfc assertion failed");

// next-cycle implication, disabled in reset
`define PFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfc assertion failed");

`endif

[src/pfc_pkg.sv]
// Types and constants of the Playfair digraph cipher
package pfc_pkg;

   localparam int SIDE     = 5;
   localparam int LETTER_W = 5;
   localparam int ROW_W    = SIDE * LETTER_W;
   localparam int COORD_W  = 3;
   localparam int CSR_IDX_W = 3;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [COORD_W-1:0]  coord_type;
   typedef logic [ROW_W-1:0]    row_type;
   typedef logic [SIDE-1:0][ROW_W-1:0] square_type;

   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_X = 5'd23;

   localparam logic [CSR_IDX_W-1:0] REG_SQUARE_ROW0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SQUARE_ROW1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SQUARE_ROW2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SQUARE_ROW3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SQUARE_ROW4 = 3'd4;

   typedef struct packed {
      logic       vld;
      logic       dec;
      logic       last;
      logic       has_a;
      logic       has_b;
      letter_type a1;
      letter_type b1;
      letter_type a2;
      letter_type b2;
   } work_type;

endpackage

[src/pfc_transform.sv]
// Playfair square lookup and digraph substitution for one letter pair
module pfc_transform (
   input  pfc_pkg::square_type square,
   input  pfc_pkg::letter_type in_a,
   input  pfc_pkg::letter_type in_b,
   input  logic                dec,
   output pfc_pkg::letter_type out_a,
   output pfc_pkg::letter_type out_b
);
   import pfc_pkg::*;

   function automatic letter_type pick(input row_type row, input coord_type col);
      letter_type res;
      res = '0;
      case (col)
         3'd0: res = row[0*LETTER_W +: LETTER_W];
         3'd1: res = row[1*LETTER_W +: LETTER_W];
         3'd2: res = row[2*LETTER_W +: LETTER_W];
         3'd3: res = row[3*LETTER_W +: LETTER_W];
         3'd4: res = row[4*LETTER_W +: LETTER_W];
         default: res = '0;
      endcase
      return res;
   endfunction

   function automatic coord_type shift(input coord_type c, input logic back);
      coord_type res;
      if (back) begin
         res = (c == '0) ? COORD_W'(SIDE - 1) : c - 1'b1;
      end else begin
         res = (c == COORD_W'(SIDE - 1)) ? '0 : c + 1'b1;
      end
      return res;
   endfunction

   coord_type r1, c1, r2, c2;

   // last match in row-major order wins
   always_comb begin
      r1 = '0;
      c1 = '0;
      r2 = '0;
      c2 = '0;
      for (int i = 0; i < SIDE; i++) begin
         for (int j = 0; j < SIDE; j++) begin
            if (square[i][j*LETTER_W +: LETTER_W] == in_a) begin
               r1 = COORD_W'(i);
               c1 = COORD_W'(j);
            end
            if (square[i][j*LETTER_W +: LETTER_W] == in_b) begin
               r2 = COORD_W'(i);
               c2 = COORD_W'(j);
            end
         end
      end
   end

   always_comb begin
      if (r1 == r2) begin
         out_a = pick(square[r1], shift(c1, dec));
         out_b = pick(square[r1], shift(c2, dec));
      end else if (c1 == c2) begin
         out_a = pick(square[shift(r1, dec)], c1);
         out_b = pick(square[shift(r2, dec)], c1);
      end else begin
         out_a = pick(square[r1], c2);
         out_b = pick(square[r2], c1);
      end
   end

endmodule

[src/pfc_pair.sv]
// Input stage: pending letter, pairing rules and the work register
module pfc_pair (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  pfc_pkg::letter_type letter_raw,
   input  logic                dec,
   input  logic                last,
   input  logic                load,
   output pfc_pkg::work_type   work
);
   import pfc_pkg::*;

   `include "playfair_digraph_cipher_defines.svh"

   logic       work_vld_ff, work_vld_in;
   work_type   work_ff, work_in;
   logic       pv_ff, pv_in;
   letter_type pl_ff;
   letter_type letter;
   logic       acc;
   logic       same;
   logic       pv_mid;

   assign letter     = (letter_raw == LETTER_J) ? LETTER_I : letter_raw;
   assign req_tready = !work_vld_ff || load;
   assign acc        = req_tvalid && req_tready;
   assign same       = (pl_ff == letter);
   assign pv_mid     = pv_ff ? same : 1'b1;

   always_comb begin
      work_vld_in = work_vld_ff && !load;
      work_in     = work_ff;
      pv_in       = pv_ff;
      if (acc) begin
         work_vld_in   = 1'b1;
         work_in.vld   = 1'b1;
         work_in.dec   = dec;
         work_in.last  = last;
         work_in.has_a = pv_ff;
         work_in.a1    = pl_ff;
         work_in.a2    = letter;
         work_in.b2    = LETTER_X;
         if (!dec) begin
            work_in.b1    = same ? LETTER_X : letter;
            work_in.has_b = last && pv_mid;
            pv_in         = pv_mid && !last;
         end else begin
            work_in.b1    = letter;
            work_in.has_b = 1'b0;
            pv_in         = !pv_ff && !last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_vld_ff <= 1'b0;
         pv_ff       <= 1'b0;
      end else begin
         work_vld_ff <= work_vld_in;
         pv_ff       <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (acc) begin
         pl_ff <= letter;
      end
   end

   always_comb begin
      work     = work_ff;
      work.vld = work_vld_ff;
   end

   `PFC_ASSERT_NEXT(a_last_clears_pending, clock, reset, acc && last, !pv_ff)
   `PFC_ASSERT_NOW(a_tail_only_encrypt, clock, reset, work_vld_ff && work_ff.has_b,
                   !work_ff.dec)
   `PFC_ASSERT_NEXT(a_pair_completes, clock, reset, acc && !dec && pv_ff && !same,
                    !pv_ff && work_ff.has_a)

endmodule

[src/pfc_drain.sv]
// Result buffer: holds up to four letters of one word and hands them out in order
module pfc_drain (
   input  logic                clock,
   input  logic                reset,
   input  pfc_pkg::work_type   work,
   input  pfc_pkg::letter_type oa1,
   input  pfc_pkg::letter_type ob1,
   input  pfc_pkg::letter_type oa2,
   input  pfc_pkg::letter_type ob2,
   output logic                load,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output pfc_pkg::letter_type out_letter,
   output logic                run_last,
   output logic                message_end
);
   import pfc_pkg::*;

   `include "playfair_digraph_cipher_defines.svh"

   logic [3:0]      mask_ff, mask_in;
   letter_type [3:0] slot_ff;
   logic            last_ff;
   logic [3:0]      sel;
   logic [3:0]      new_mask;
   logic            rsp_acc;

   assign sel         = mask_ff & (~mask_ff + 4'd1);
   assign rsp_tvalid  = |mask_ff;
   assign rsp_acc     = rsp_tvalid && rsp_tready;
   assign run_last    = ((mask_ff & ~sel) == 4'd0);
   assign message_end = run_last && last_ff;
   assign load        = work.vld && (!rsp_tvalid || (rsp_acc && run_last));

   // drop X from plain text
   assign new_mask[0] = work.has_a && !(work.dec && (oa1 == LETTER_X));
   assign new_mask[1] = work.has_a && !(work.dec && (ob1 == LETTER_X));
   assign new_mask[2] = work.has_b;
   assign new_mask[3] = work.has_b;

   always_comb begin
      out_letter = '0;
      for (int k = 0; k < 4; k++) begin
         out_letter = out_letter | (slot_ff[k] & {LETTER_W{sel[k]}});
      end
   end

   always_comb begin
      mask_in = mask_ff;
      if (rsp_acc) begin
         mask_in = mask_ff & ~sel;
      end
      if (load) begin
         mask_in = new_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= {ob2, oa2, ob1, oa1};
         last_ff <= work.last;
      end
   end

   `PFC_ASSERT_NEXT(a_run_drains, clock, reset, rsp_acc && run_last && !load,
                    mask_ff == 4'd0)
   `PFC_ASSERT_NOW(a_end_on_run_last, clock, reset, rsp_tvalid && message_end, run_last)
   `PFC_ASSERT_NEXT(a_decrypt_two_max, clock, reset, load && work.dec,
                    mask_ff[3:2] == 2'b00)

endmodule

[src/playfair_digraph_cipher.sv]
// Playfair digraph cipher: an accepted req word goes to the work register, then to the
// result buffer, which hands out the rsp words one at a time. A word may be accepted
// every cycle while the work register is empty or its word moves to the result buffer.
// The square lookup of both pairs sits between the work register and the result buffer.
// Synchronous active-high reset clears the pending letter, both stages and the square.
// Config takes effect at once; the square registers reset to zero.
module playfair_digraph_cipher (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,  // [4:0] in_letter
   input  logic                         req_tuser,  // req_type
   input  logic                         req_tlast,  // message_last
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,  // [4:0] out_letter
   output logic                         rsp_tuser,  // run_last
   output logic                         rsp_tlast,  // message_end
   input  logic                         csr_wr_en,
   input  logic [pfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pfc_pkg::ROW_W-1:0]     csr_wdata
);
   import pfc_pkg::*;

   square_type square_ff;
   work_type   work;
   letter_type oa1, ob1, oa2, ob2;
   letter_type out_letter;
   logic       load;

   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SQUARE_ROW0: square_ff[0] <= csr_wdata;
            REG_SQUARE_ROW1: square_ff[1] <= csr_wdata;
            REG_SQUARE_ROW2: square_ff[2] <= csr_wdata;
            REG_SQUARE_ROW3: square_ff[3] <= csr_wdata;
            REG_SQUARE_ROW4: square_ff[4] <= csr_wdata;
            default: ;
         endcase
      end
   end

   pfc_pair u_pair (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .letter_raw (req_tdata[LETTER_W-1:0]),
      .dec        (req_tuser),
      .last       (req_tlast),
      .load       (load),
      .work       (work)
   );

   pfc_transform u_xform_a (
      .square (square_ff),
      .in_a   (work.a1),
      .in_b   (work.b1),
      .dec    (work.dec),
      .out_a  (oa1),
      .out_b  (ob1)
   );

   pfc_transform u_xform_b (
      .square (square_ff),
      .in_a   (work.a2),
      .in_b   (work.b2),
      .dec    (1'b0),
      .out_a  (oa2),
      .out_b  (ob2)
   );

   pfc_drain u_drain (
      .clock       (clock),
      .reset       (reset),
      .work        (work),
      .oa1         (oa1),
      .ob1         (ob1),
      .oa2         (oa2),
      .ob2         (ob2),
      .load        (load),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .out_letter  (out_letter),
      .run_last    (rsp_tuser),
      .message_end (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, out_letter};

endmodule

[test/playfair_digraph_cipher_checker.sv]
// Checker for the Playfair digraph cipher: tracks the square, predicts and compares rsp words
module playfair_digraph_cipher_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [4:0] in_letter
   input  logic                          req_tuser,   // req_type
   input  logic                          req_tlast,   // message_last
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [7:0]                    rsp_tdata,   // [4:0] out_letter
   input  logic                          rsp_tuser,   // run_last
   input  logic                          rsp_tlast,   // message_end
   input  logic                          csr_wr_en,
   input  logic [pfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pfc_pkg::ROW_W-1:0]     csr_wdata,
   output int                            fail_count,
   output int                            expected_left
);
   timeunit 1ns;
   timeprecision 1ps;

   import pfc_pkg::*;

   typedef struct packed {
      letter_type letter;
      logic       run_last;
      logic       msg_end;
   } cipher_word_type;

   cipher_word_type cipher_words[$];
   square_type      key_square;
   logic            held_valid;
   letter_type      held_letter;
   int              mismatches = 0;

   function automatic letter_type square_at(int r, int c);
      return key_square[r % SIDE][LETTER_W*(c % SIDE) +: LETTER_W];
   endfunction

   // last match in row-major order wins; absent letters sit at row 0, column 0
   function automatic void find_letter(letter_type l, output int r, output int c);
      r = 0;
      c = 0;
      for (int i = 0; i < SIDE; i++)
         for (int j = 0; j < SIDE; j++)
            if (square_at(i, j) == l) begin
               r = i;
               c = j;
            end
   endfunction

   function automatic void cipher_pair(letter_type a, letter_type b, int shift,
                                       output letter_type oa, output letter_type ob);
      int r1, c1, r2, c2;
      find_letter(a, r1, c1);
      find_letter(b, r2, c2);
      if (r1 == r2) begin
         oa = square_at(r1, c1 + shift);
         ob = square_at(r1, c2 + shift);
      end else if (c1 == c2) begin
         oa = square_at(r1 + shift, c1);
         ob = square_at(r2 + shift, c1);
      end else begin
         oa = square_at(r1, c2);
         ob = square_at(r2, c1);
      end
   endfunction

   function automatic void plan_cipher_words(logic decrypt, letter_type in_letter, logic last);
      letter_type      outs[$];
      letter_type      l, a, b;
      cipher_word_type w;
      l = (in_letter == LETTER_J) ? LETTER_I : in_letter;
      if (!decrypt) begin
         if (held_valid) begin
            if (held_letter == l) begin
               cipher_pair(held_letter, LETTER_X, 1, a, b);
               outs.push_back(a);
               outs.push_back(b);
               held_letter = l;
            end else begin
               cipher_pair(held_letter, l, 1, a, b);
               outs.push_back(a);
               outs.push_back(b);
               held_valid = 1'b0;
            end
         end else begin
            held_valid  = 1'b1;
            held_letter = l;
         end
         if (last && held_valid) begin
            cipher_pair(held_letter, LETTER_X, 1, a, b);
            outs.push_back(a);
            outs.push_back(b);
            held_valid = 1'b0;
         end
      end else begin
         if (held_valid) begin
            cipher_pair(held_letter, l, SIDE - 1, a, b);
            if (a != LETTER_X) outs.push_back(a);
            if (b != LETTER_X) outs.push_back(b);
            held_valid = 1'b0;
         end else begin
            held_valid  = 1'b1;
            held_letter = l;
         end
         if (last) held_valid = 1'b0;
      end
      foreach (outs[k]) begin
         w.letter   = outs[k];
         w.run_last = (k == outs.size() - 1);
         w.msg_end  = w.run_last && last;
         cipher_words.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      cipher_word_type want;
      if (reset) begin
         key_square  = '0;
         held_valid  = 1'b0;
         held_letter = '0;
         cipher_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_words.size() == 0) begin
               $error("out_letter: no word expected, got %0d", rsp_tdata[LETTER_W-1:0]);
               mismatches++;
            end else begin
               want = cipher_words.pop_front();
               if (rsp_tdata[LETTER_W-1:0] !== want.letter) begin
                  $error("out_letter: expected %0d, got %0d", want.letter,
                         rsp_tdata[LETTER_W-1:0]);
                  mismatches++;
               end
               if (rsp_tuser !== want.run_last) begin
                  $error("run_last: expected %0d, got %0d", want.run_last, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tlast !== want.msg_end) begin
                  $error("message_end: expected %0d, got %0d", want.msg_end, rsp_tlast);
                  mismatches++;
               end
            end
         end
         if (csr_wr_en && csr_index < SIDE) key_square[csr_index] = csr_wdata;
         if (req_tvalid && req_tready)
            plan_cipher_words(req_tuser, req_tdata[LETTER_W-1:0], req_tlast);
      end
      fail_count    <= mismatches;
      expected_left <= cipher_words.size();
   end

endmodule

[test/playfair_digraph_cipher_tb.sv]
// Testbench top for the Playfair digraph cipher: square settings, letter stimulus and verdict
module playfair_digraph_cipher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfc_pkg::*;

   localparam logic ENCRYPT        = 1'b0;
   localparam logic DECRYPT        = 1'b1;
   localparam int   ALPHABET       = 26;
   localparam int   WATCHDOG_LIMIT = 3000;
   localparam int   LONG_HOLD      = 400;
   localparam int   PHASE_WORDS    = 45;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;   // [4:0] in_letter
   logic                 req_tuser  = 1'b0; // req_type
   logic                 req_tlast  = 1'b0; // message_last
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;         // [4:0] out_letter
   logic                 rsp_tuser;         // run_last
   logic                 rsp_tlast;         // message_end
   logic                 csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [ROW_W-1:0]     csr_wdata  = '0;

   int fail_count;
   int expected_left;
   int words_sent   = 0;
   int quiet_cycles = 0;
   int phase_words  = 0;
   bit no_gaps      = 1'b0;

   playfair_digraph_cipher u_top (.*);

   playfair_digraph_cipher_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (req_tvalid && req_tready) words_sent <= words_sent + 1;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic letter_type letter_of(byte ch);
      return letter_type'(ch - "A");
   endfunction

   function automatic logic [CSR_IDX_W-1:0] row_register(int r);
      case (r)
         0:       return REG_SQUARE_ROW0;
         1:       return REG_SQUARE_ROW1;
         2:       return REG_SQUARE_ROW2;
         3:       return REG_SQUARE_ROW3;
         default: return REG_SQUARE_ROW4;
      endcase
   endfunction

   function automatic square_type alphabet_square(bit shuffle);
      letter_type cells[SIDE*SIDE];
      letter_type swap;
      square_type sq;
      int         n;
      int         j;
      n = 0;
      for (int c = 0; c < ALPHABET; c++)
         if (letter_type'(c) != LETTER_J) begin
            cells[n] = letter_type'(c);
            n++;
         end
      if (shuffle)
         for (int k = SIDE*SIDE - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            swap     = cells[k];
            cells[k] = cells[j];
            cells[j] = swap;
         end
      for (int k = 0; k < SIDE*SIDE; k++)
         sq[k / SIDE][LETTER_W*(k % SIDE) +: LETTER_W] = cells[k];
      return sq;
   endfunction

   function automatic square_type scattered_square(int top_code);
      square_type sq;
      for (int k = 0; k < SIDE*SIDE; k++)
         sq[k / SIDE][LETTER_W*(k % SIDE) +: LETTER_W] = letter_type'($urandom_range(0, top_code));
      return sq;
   endfunction

   function automatic int sender_gap();
      int roll;
      if (no_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic load_square(input square_type sq);
      for (int r = 0; r < SIDE; r++) begin
         csr_wr_en <= 1'b1;
         csr_index <= row_register(r);
         csr_wdata <= sq[r];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_letter(input logic mode, input letter_type letter, input logic last);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {3'b000, letter};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      phase_words++;
   endtask

   // doubled letters and X come often; now and then a letter flips the mode
   task automatic send_message(input logic mode, input int len);
      letter_type prev;
      letter_type l;
      int         roll;
      prev = LETTER_X;
      for (int k = 0; k < len; k++) begin
         roll = $urandom_range(0, 99);
         if (k > 0 && roll < 20)
            l = prev;
         else if (roll < 30)
            l = LETTER_X;
         else if (roll < 35)
            l = LETTER_J;
         else
            l = letter_type'($urandom_range(0, ALPHABET - 1));
         send_letter(($urandom_range(0, 99) < 4) ? !mode : mode, l, k == len - 1);
         prev = l;
      end
   endtask

   // drop valid, hold until every expected word has come, then let the pipeline drain
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      bit held;
      int span;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (!held && words_sent >= 200) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         span = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               rsp_tready <= 1'b1;
               repeat (span * 4) @(posedge clock);
            end
            3: begin
               rsp_tready <= 1'b0;
               repeat (span) @(posedge clock);
            end
            default: begin
               repeat (span * 2) begin
                  rsp_tready <= ($urandom_range(0, 3) != 0);
                  @(posedge clock);
               end
            end
         endcase
      end
   end

   initial begin
      square_type sq;
      int         len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // square still at reset: every letter but A sits at row 0, column 0
      send_letter(ENCRYPT, letter_of("A"), 1'b0);
      send_letter(ENCRYPT, letter_of("Z"), 1'b1);
      send_letter(DECRYPT, letter_of("P"), 1'b1);
      settle();

      load_square(alphabet_square(1'b0));
      send_letter(ENCRYPT, letter_of("A"), 1'b0);
      send_letter(ENCRYPT, letter_of("B"), 1'b0);
      send_letter(ENCRYPT, letter_of("F"), 1'b0);
      send_letter(ENCRYPT, letter_of("A"), 1'b0);
      send_letter(ENCRYPT, letter_of("G"), 1'b0);
      send_letter(ENCRYPT, letter_of("Z"), 1'b1);
      send_letter(ENCRYPT, letter_of("L"), 1'b0);
      send_letter(ENCRYPT, letter_of("L"), 1'b1);
      send_letter(ENCRYPT, LETTER_X, 1'b0);
      send_letter(ENCRYPT, LETTER_X, 1'b1);
      send_letter(ENCRYPT, LETTER_I, 1'b0);
      send_letter(ENCRYPT, LETTER_J, 1'b1);
      send_letter(ENCRYPT, letter_of("Z"), 1'b1);
      send_letter(DECRYPT, letter_of("Y"), 1'b0);
      send_letter(DECRYPT, letter_of("Y"), 1'b0);
      send_letter(DECRYPT, letter_of("Y"), 1'b0);
      send_letter(DECRYPT, letter_of("V"), 1'b0);
      send_letter(DECRYPT, letter_of("K"), 1'b1);
      send_letter(ENCRYPT, letter_of("A"), 1'b0);
      send_letter(DECRYPT, letter_of("B"), 1'b1);
      settle();

      // all codes 31: no letter found
      load_square('1);
      send_letter(ENCRYPT, letter_of("B"), 1'b0);
      send_letter(ENCRYPT, letter_of("C"), 1'b1);
      settle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0, 4:    sq = alphabet_square(1'b1);
            1, 6:    sq = scattered_square(31);
            2:       sq = alphabet_square(1'b0);
            3:       sq = scattered_square(3);
            5:       sq = '1;
            default: sq = '0;
         endcase
         no_gaps = (p == 2);
         load_square(sq);
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            send_message(logic'($urandom_range(0, 1)), len);
         end
         settle();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/pfc_pkg.sv
src/pfc_transform.sv
src/pfc_pair.sv
src/pfc_drain.sv
src/playfair_digraph_cipher.sv
test/playfair_digraph_cipher_checker.sv
test/playfair_digraph_cipher_tb.sv
